// File: src/afm_pkg.sv
`default_nettype none

package afm_pkg;

  // Default table geometry
  localparam int unsigned MAX_SYMBOLS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF  = 17;

  // Fixed field widths
  localparam int unsigned ALPH_W  = 9;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned VAL_W   = 17;

  // APB port geometry
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register reset values
  localparam logic [ALPH_W-1:0]  ALPH_RST  = 9'd256;
  localparam logic [STEP_W-1:0]  STEP_RST  = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'hFFFF;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_ALPHABET = 2'd0,
    REG_STEP     = 2'd1,
    REG_LIMIT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ALPH_W-1:0]  alphabet;
    logic [STEP_W-1:0]  step;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_restart;
    logic clr_step;
    logic accept;
    logic scan_start;
    logic scan_step;
    logic emit;
    logic rs_start;
    logic rs_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic range_err;
    logic hit;
    logic miss;
    logic out_free;
    logic rescale_need;
    logic rs_last;
  } stat_t;

endpackage

`default_nettype wire

// File: src/adaptive_frequency_model_core.sv
// Adaptive frequency model: one count per symbol in a table with one read and one write port,
// walked one entry per cycle. The result of an item (encode by symbol, decode by target) is
// offered once the walk reaches the symbol's position (the symbol for encode, the decoded
// symbol for decode); an out-of-range item skips the walk and gives its error result. The
// next item is taken only after a result is loaded. When the bumped total reaches the
// rescale limit, a rescale walk over the symbols in use follows before the next item is
// taken. After reset and after every register write the whole table of MAX_SYMBOLS entries
// is cleared, during which no item is taken. A finished result sits in an output register,
// so the next item may enter while it waits for its transfer.
`default_nettype none

module adaptive_frequency_model_core
  import afm_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [SYM_W-1:0]  symbol_in_i,
  input  logic [VAL_W-1:0]  target_i,
  // Results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SYM_W-1:0]  symbol_out_o,
  output logic [VAL_W-1:0]  cum_low_o,
  output logic [VAL_W-1:0]  cum_high_o,
  output logic [VAL_W-1:0]  total_o,
  output logic              error_o
);

  cfg_t  cfg;
  logic  cfg_wr;
  cmd_t  cmd;
  stat_t stat;

  afm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  afm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  afm_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .symbol_in_i  (symbol_in_i),
    .target_i     (target_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .symbol_out_o (symbol_out_o),
    .cum_low_o    (cum_low_o),
    .cum_high_o   (cum_high_o),
    .total_o      (total_o),
    .error_o      (error_o)
  );

endmodule

`default_nettype wire

// File: src/afm_regs.sv
`default_nettype none

module afm_regs
  import afm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              cfg_wr_o
);

  logic [ALPH_W-1:0]  alph_q;
  logic [STEP_W-1:0]  step_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [1:0]         widx;
  logic               wr_en;
  logic               idx_ok;

  assign pready = 1'b1;
  assign widx   = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  // Valid register index decode
  always_comb begin
    unique case (widx) inside
      REG_ALPHABET, REG_STEP, REG_LIMIT: idx_ok = 1'b1;
      default:                           idx_ok = 1'b0;
    endcase
  end

  assign cfg_wr_o = wr_en & idx_ok;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q  <= ALPH_RST;
      step_q  <= STEP_RST;
      limit_q <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (widx)
        REG_ALPHABET: alph_q  <= pwdata[ALPH_W-1:0];
        REG_STEP:     step_q  <= pwdata[STEP_W-1:0];
        REG_LIMIT:    limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (widx)
      REG_ALPHABET: prdata = {{(APB_DW-ALPH_W){1'b0}}, alph_q};
      REG_STEP:     prdata = {{(APB_DW-STEP_W){1'b0}}, step_q};
      REG_LIMIT:    prdata = {{(APB_DW-LIMIT_W){1'b0}}, limit_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.alphabet = alph_q;
  assign cfg_o.step     = step_q;
  assign cfg_o.limit    = limit_q;

endmodule

`default_nettype wire

// File: src/afm_ctrl.sv
`default_nettype none

module afm_ctrl
  import afm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_wr_i,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_START    = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;
  localparam logic [2:0] ST_RS_START = 3'd5;
  localparam logic [2:0] ST_RS       = 3'd6;

  logic [2:0] state_q, state_d;

  // Input is taken only when idle and no register write is landing
  assign in_stall_o = (state_q != ST_IDLE) | cfg_wr_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (cfg_wr_i) begin
      cmd_o.clr_restart = 1'b1;
      state_d           = ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          cmd_o.clr_step = 1'b1;
          if (stat_i.clr_last) state_d = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            state_d      = ST_START;
          end
        end
        ST_START: begin
          cmd_o.scan_start = 1'b1;
          state_d          = stat_i.range_err ? ST_EMIT : ST_SCAN;
        end
        ST_SCAN: begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.hit || stat_i.miss) state_d = ST_EMIT;
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = stat_i.rescale_need ? ST_RS_START : ST_IDLE;
          end
        end
        ST_RS_START: begin
          cmd_o.rs_start = 1'b1;
          state_d        = ST_RS;
        end
        ST_RS: begin
          cmd_o.rs_step = 1'b1;
          if (stat_i.rs_last) state_d = ST_IDLE;
        end
        default: state_d = ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/afm_dp.sv
`default_nettype none

module afm_dp
  import afm_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             mode_i,
  input  logic [SYM_W-1:0] symbol_in_i,
  input  logic [VAL_W-1:0] target_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [SYM_W-1:0] symbol_out_o,
  output logic [VAL_W-1:0] cum_low_o,
  output logic [VAL_W-1:0] cum_high_o,
  output logic [VAL_W-1:0] total_o,
  output logic             error_o
);

  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned IW = AW + 1;
  localparam int unsigned NW = (IW > ALPH_W) ? IW : ALPH_W;
  localparam int unsigned SW = (IW > SYM_W) ? IW : SYM_W;
  localparam int unsigned TW = (CW > VAL_W) ? CW : VAL_W;
  localparam int unsigned HW = TW + 1;
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned XW = (IW > CW) ? IW : CW;

  // Count table
  logic [CW-1:0] mem_q [MAX_SYMBOLS];
  logic [CW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Item and walk state
  logic             mode_q;
  logic [SYM_W-1:0] sym_in_q;
  logic [VAL_W-1:0] tgt_q;
  logic [IW-1:0]    rd_idx_q;
  logic [IW-1:0]    cur_q;
  logic [VAL_W-1:0] lo_q;
  logic [IW-1:0]    hit_idx_q;
  logic [CW-1:0]    hit_cnt_q;
  logic             err_q;
  logic [CW-1:0]    total_q;
  logic [IW-1:0]    clr_idx_q;

  // Result register
  logic             out_valid_q;
  logic [SYM_W-1:0] symbol_out_q;
  logic [VAL_W-1:0] cum_low_q;
  logic [VAL_W-1:0] cum_high_q;
  logic [VAL_W-1:0] total_out_q;
  logic             error_out_q;

  logic [NW-1:0]  alph_w;
  logic [NW-1:0]  nsym_w;
  logic [IW-1:0]  nsym;
  logic [IW-1:0]  last_idx;
  logic [XW-1:0]  nsym_x;
  logic [SW-1:0]  sym_cmp;
  logic [SW-1:0]  cur_cmp;
  logic [SW-1:0]  hit_sym_x;
  logic           range_err;
  logic [HW-1:0]  hi_full;
  logic [HW-1:0]  cum_high_full;
  logic           hit;
  logic           is_last;
  logic [CW-1:0]  bump_cnt;
  logic [CW-1:0]  total_bump;
  logic [CW-1:0]  half_cnt;
  logic [TW-1:0]  total_x;

  // Symbols in use: alphabet register clamped to [2, MAX_SYMBOLS]
  assign alph_w = NW'(cfg_i.alphabet);
  always_comb begin
    if (alph_w < NW'(2)) begin
      nsym_w = NW'(2);
    end else if (alph_w > NW'(MAX_SYMBOLS)) begin
      nsym_w = NW'(MAX_SYMBOLS);
    end else begin
      nsym_w = alph_w;
    end
  end
  assign nsym     = nsym_w[IW-1:0];
  assign last_idx = nsym - IW'(1);
  assign nsym_x   = XW'(nsym);

  // Range checks on the latched item
  assign sym_cmp   = SW'(sym_in_q);
  assign range_err = mode_q ? (TW'(tgt_q) >= TW'(total_q)) : (sym_cmp >= SW'(nsym));

  // Walk compare: decode stops inside the interval, encode at the symbol
  assign cur_cmp = SW'(cur_q);
  assign hi_full = HW'(lo_q) + HW'(rdata_q);
  assign hit     = mode_q ? (HW'(tgt_q) < hi_full) : (cur_cmp == sym_cmp);
  assign is_last = (cur_q == last_idx);

  // Update arithmetic
  assign bump_cnt      = hit_cnt_q + CW'(cfg_i.step);
  assign total_bump    = total_q + CW'(cfg_i.step);
  assign half_cnt      = (rdata_q >> 1) + CW'(1);
  assign cum_high_full = HW'(lo_q) + HW'(hit_cnt_q);
  assign total_x       = TW'(total_q);
  assign hit_sym_x     = SW'(hit_idx_q);

  // Status
  assign stat_o.clr_last     = (clr_idx_q == IW'(MAX_SYMBOLS - 1));
  assign stat_o.range_err    = range_err;
  assign stat_o.hit          = hit;
  assign stat_o.miss         = !hit && is_last;
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;
  assign stat_o.rescale_need = !err_q && (LW'(total_bump) >= LW'(cfg_i.limit));
  assign stat_o.rs_last      = is_last;

  // Table port selection
  assign mem_raddr = (cmd_i.scan_start || cmd_i.rs_start) ? '0 : rd_idx_q[AW-1:0];
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_q[AW-1:0];
    mem_wdata = CW'(1);
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.emit && !err_q) begin
      mem_we    = 1'b1;
      mem_waddr = hit_idx_q[AW-1:0];
      mem_wdata = bump_cnt;
    end else if (cmd_i.rs_step) begin
      mem_we    = 1'b1;
      mem_waddr = cur_q[AW-1:0];
      mem_wdata = half_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      err_q       <= 1'b0;
    end else begin
      if (cmd_i.clr_restart) begin
        clr_idx_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + IW'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Total: reload after clear, bump, or re-sum during rescale
      if (cmd_i.clr_step && stat_o.clr_last) begin
        total_q <= nsym_x[CW-1:0];
      end else if (cmd_i.emit && !err_q) begin
        total_q <= total_bump;
      end else if (cmd_i.rs_start) begin
        total_q <= '0;
      end else if (cmd_i.rs_step) begin
        total_q <= total_q + half_cnt;
      end

      if (cmd_i.scan_start) begin
        err_q <= range_err;
      end else if (cmd_i.scan_step && !hit && is_last) begin
        err_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_i;
      sym_in_q <= symbol_in_i;
      tgt_q    <= target_i;
    end

    // Read pointer runs one entry ahead of the data in rdata_q
    if (cmd_i.scan_start || cmd_i.rs_start) begin
      rd_idx_q <= IW'(1);
      cur_q    <= '0;
    end else if (cmd_i.scan_step || cmd_i.rs_step) begin
      rd_idx_q <= rd_idx_q + IW'(1);
      cur_q    <= rd_idx_q;
    end

    if (cmd_i.scan_start) begin
      lo_q <= '0;
    end else if (cmd_i.scan_step && !hit) begin
      lo_q <= hi_full[VAL_W-1:0];
    end

    if (cmd_i.scan_step && hit) begin
      hit_idx_q <= cur_q;
      hit_cnt_q <= rdata_q;
    end

    if (cmd_i.emit) begin
      error_out_q <= err_q;
      total_out_q <= total_x[VAL_W-1:0];
      if (err_q) begin
        symbol_out_q <= mode_q ? '0 : sym_in_q;
        cum_low_q    <= '0;
        cum_high_q   <= '0;
      end else begin
        symbol_out_q <= hit_sym_x[SYM_W-1:0];
        cum_low_q    <= lo_q;
        cum_high_q   <= cum_high_full[VAL_W-1:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = symbol_out_q;
  assign cum_low_o    = cum_low_q;
  assign cum_high_o   = cum_high_q;
  assign total_o      = total_out_q;
  assign error_o      = error_out_q;

endmodule

`default_nettype wire

// File: src/afm_chk.sv
`default_nettype none

module afm_chk
  import afm_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_i,
  input wire logic             out_valid_i,
  input wire logic             out_stall_i,
  input wire logic [SYM_W-1:0] symbol_out_i,
  input wire logic [VAL_W-1:0] cum_low_i,
  input wire logic [VAL_W-1:0] cum_high_i,
  input wire logic             error_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(symbol_out_i) && $stable(cum_low_i)
      && $stable(cum_high_i) && $stable(error_i))
    else $error("result payload changed while stalled");

  // One item at a time: the block is busy right after a transfer in
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second item taken back to back");

  // An error result carries an empty interval
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i |-> (cum_low_i == '0) && (cum_high_i == '0))
    else $error("error result with nonzero interval");

endmodule

bind adaptive_frequency_model_core afm_chk u_afm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .symbol_out_i (symbol_out_o),
  .cum_low_i    (cum_low_o),
  .cum_high_i   (cum_high_o),
  .error_i      (error_o)
);

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
  import afm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF;
  localparam int unsigned CNT_W       = COUNT_BITS_DEF;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] tot;
    logic             err;
  } interval_t;

  typedef struct packed {
    row_kind_e        kind;
    reg_idx_e         idx;
    logic [31:0]      value;
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] tgt;
    logic             typed;
    interval_t        res;
  } stim_row_t;

  localparam interval_t NO_RES = '0;

  // DUT connections
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              mode_i      = 1'b0;
  logic [SYM_W-1:0]  symbol_in_i = '0;
  logic [VAL_W-1:0]  target_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SYM_W-1:0]  symbol_out_o;
  logic [VAL_W-1:0]  cum_low_o;
  logic [VAL_W-1:0]  cum_high_o;
  logic [VAL_W-1:0]  total_o;
  logic              error_o;

  adaptive_frequency_model_core i_dut (.*);

  always #2 clk_i = ~clk_i;

  // Frequency table shadow
  logic [ALPH_W-1:0]  alph_reg;
  logic [STEP_W-1:0]  step_reg;
  logic [LIMIT_W-1:0] limit_reg;
  logic [CNT_W-1:0]   freq_count [MAX_SYMBOLS];
  logic [CNT_W-1:0]   freq_total;

  interval_t interval_q [$];
  int        mismatches    = 0;
  int        burst_left    = 0;
  bit        hold_request  = 1'b0;

  // out-of-range alphabet values clamp to 2..MAX_SYMBOLS
  function automatic int unsigned used_syms();
    if (alph_reg < 2) return 2;
    if (alph_reg > MAX_SYMBOLS) return MAX_SYMBOLS;
    return 32'(alph_reg);
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < MAX_SYMBOLS; i++) freq_count[i] = CNT_W'(1);
    freq_total = CNT_W'(used_syms());
  endfunction

  function automatic void apply_cfg(reg_idx_e idx, logic [31:0] val);
    case (idx)
      REG_ALPHABET: alph_reg = val[ALPH_W-1:0];
      REG_STEP:     step_reg = val[STEP_W-1:0];
      default:      limit_reg = val[LIMIT_W-1:0];
    endcase
    clear_counts();
  endfunction

  // Look up the coder interval for one item, then adapt the table
  function automatic interval_t code_symbol(op_e op, logic [SYM_W-1:0] s,
                                            logic [VAL_W-1:0] t);
    interval_t   r;
    int unsigned n;
    logic [31:0] lo, hi;
    bit          hit;
    logic [SYM_W-1:0] pick;
    n    = used_syms();
    lo   = 0;
    hit  = 1'b0;
    pick = s;
    if (op == OP_ENCODE) begin
      if (s < n) begin
        for (int i = 0; i < s; i++) lo += freq_count[i];
        hit = 1'b1;
      end
    end else begin
      if (t < freq_total) begin
        for (int i = 0; i < n && !hit; i++) begin
          hi = lo + freq_count[i];
          if (t < hi) begin
            pick = i[SYM_W-1:0];
            hit  = 1'b1;
          end else begin
            lo = hi;
          end
        end
      end
      if (!hit) pick = '0;
    end
    r.sym = pick;
    r.tot = freq_total;
    if (!hit) begin
      r.lo  = '0;
      r.hi  = '0;
      r.err = 1'b1;
      return r;
    end
    hi    = lo + freq_count[pick];
    r.lo  = lo[VAL_W-1:0];
    r.hi  = hi[VAL_W-1:0];
    r.err = 1'b0;
    // adapt, then halve everything in use once the limit is hit
    freq_count[pick] = freq_count[pick] + step_reg;
    freq_total       = freq_total + step_reg;
    if (freq_total >= limit_reg) begin
      freq_total = '0;
      for (int i = 0; i < n; i++) begin
        freq_count[i] = (freq_count[i] >> 1) + CNT_W'(1);
        freq_total    = freq_total + freq_count[i];
      end
    end
    return r;
  endfunction

  // APB write followed by a read back of the same register
  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    logic [31:0] want_rd;
    case (idx)
      REG_ALPHABET: want_rd = {23'd0, val[ALPH_W-1:0]};
      REG_STEP:     want_rd = {24'd0, val[STEP_W-1:0]};
      default:      want_rd = {16'd0, val[LIMIT_W-1:0]};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    apply_cfg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want_rd) begin
      $error("prdata: expected %0h, got %0h", want_rd, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain all results, then cover a trailing rescale walk
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (interval_q.size() != 0) @(posedge clk_i);
    repeat (MAX_SYMBOLS + 16) @(posedge clk_i);
  endtask

  // Offer one item in bursts; predict at the transfer edge
  task automatic offer_item(op_e op, logic [SYM_W-1:0] s, logic [VAL_W-1:0] t,
                            logic typed, interval_t typed_res);
    interval_t want;
    int        gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    symbol_in_i <= s;
    target_i    <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want = code_symbol(op, s, t);
    if (typed) want = typed_res;
    interval_q.push_back(want);
  endtask

  // Directed rows: reset state, extremes, error cases, register corners
  stim_row_t dir_table [0:27] = '{
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b1,
      '{8'd0,   17'd0,   17'd1,   17'd256, 1'b0}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd255, 17'd0,      1'b1,
      '{8'd255, 17'd256, 17'd257, 17'd257, 1'b0}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd0,   17'd0,      1'b1,
      '{8'd0,   17'd0,   17'd2,   17'd258, 1'b0}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd255, 17'd258,    1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd0,   17'd260,    1'b1,
      '{8'd0,   17'd0,   17'd0,   17'd260, 1'b1}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'hAA,  17'd131071, 1'b1,
      '{8'd0,   17'd0,   17'd0,   17'd260, 1'b1}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd128, 17'd131071, 1'b1,
      '{8'd128, 17'd130, 17'd131, 17'd260, 1'b0}},
    '{ROW_CFG,  REG_ALPHABET, 32'd2,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd2,   17'd0,      1'b1,
      '{8'd2,   17'd0,   17'd0,   17'd2,   1'b1}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd255, 17'd0,      1'b1,
      '{8'd255, 17'd0,   17'd0,   17'd2,   1'b1}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd1,   17'd0,      1'b1,
      '{8'd1,   17'd1,   17'd2,   17'd2,   1'b0}},
    '{ROW_CFG,  REG_STEP,     32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b1,
      '{8'd0,   17'd0,   17'd1,   17'd2,   1'b0}},
    '{ROW_CFG,  REG_LIMIT,    32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd1,   17'd0,      1'b1,
      '{8'd1,   17'd1,   17'd2,   17'd2,   1'b0}},
    '{ROW_CFG,  REG_STEP,     32'd255, OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd0,   17'd1,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd0,   17'd129,    1'b0, NO_RES},
    '{ROW_CFG,  REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd1,   17'd0,      1'b1,
      '{8'd1,   17'd1,   17'd2,   17'd2,   1'b0}},
    '{ROW_CFG,  REG_ALPHABET, 32'd511, OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd255, 17'd0,      1'b1,
      '{8'd255, 17'd255, 17'd256, 17'd256, 1'b0}},
    '{ROW_CFG,  REG_ALPHABET, 32'd2,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_CFG,  REG_STEP,     32'd1,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_CFG,  REG_LIMIT,    32'd3,   OP_ENCODE, 8'd0,   17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b1,
      '{8'd0,   17'd0,   17'd1,   17'd2,   1'b0}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_ENCODE, 8'd0,   17'd0,      1'b1,
      '{8'd0,   17'd0,   17'd2,   17'd3,   1'b0}},
    '{ROW_ITEM, REG_ALPHABET, 32'd0,   OP_DECODE, 8'd0,   17'd2,      1'b1,
      '{8'd1,   17'd2,   17'd3,   17'd3,   1'b0}}
  };

  // Main stimulus
  initial begin : stimulus
    int unsigned      n;
    int               sel;
    op_e              op;
    logic [SYM_W-1:0] s;
    logic [VAL_W-1:0] t;
    logic [31:0]      alph_v, step_v, limit_v;
    alph_reg  = ALPH_RST;
    step_reg  = STEP_RST;
    limit_reg = LIMIT_RST;
    clear_counts();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CFG) begin
        wait_idle();
        apb_write(dir_table[r].idx, dir_table[r].value);
      end else begin
        offer_item(dir_table[r].op, dir_table[r].sym, dir_table[r].tgt,
                   dir_table[r].typed, dir_table[r].res);
      end
    end

    // Random phases; most use small alphabets to keep the table walk short
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        4:       alph_v = 256;
        7:       alph_v = $urandom_range(257, 511);
        8:       alph_v = $urandom_range(0, 1);
        default: alph_v = $urandom_range(2, 40);
      endcase
      case (ph)
        0:       step_v = 1;
        1:       step_v = 255;
        2:       step_v = 0;
        default: step_v = $urandom_range(0, 255);
      endcase
      case (ph % 3)
        0:       limit_v = 65535;
        1:       limit_v = $urandom_range(0, 300);
        default: limit_v = $urandom_range(2, 65535);
      endcase
      wait_idle();
      apb_write(REG_ALPHABET, alph_v);
      apb_write(REG_STEP, step_v);
      apb_write(REG_LIMIT, limit_v);
      // long receiver hold-off while the first random phase keeps offering items
      if (ph == 0) hold_request = 1'b1;
      repeat (115) begin
        n   = used_syms();
        sel = $urandom_range(0, 99);
        s   = SYM_W'($urandom_range(0, 255));
        t   = VAL_W'($urandom_range(0, 131071));
        if (sel < 45) begin
          op = OP_ENCODE;
          s  = SYM_W'($urandom_range(0, n - 1));
        end else if (sel < 90) begin
          op = OP_DECODE;
          t  = VAL_W'($urandom_range(0, freq_total - 1));
        end else if (sel < 95) begin
          // symbol beyond the alphabet, when the alphabet is smaller than the table
          op = OP_ENCODE;
          if (n < MAX_SYMBOLS) s = SYM_W'($urandom_range(n, 255));
        end else begin
          // target anywhere, mostly beyond the total
          op = OP_DECODE;
        end
        offer_item(op, s, t, 1'b0, NO_RES);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver stall patterns, with one long hold-off to back up the input
  initial begin : receiver
    int pattern;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pattern = $urandom_range(0, 3);
      span    = $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk_i);
        case (pattern)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) != 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest predicted interval
  always @(posedge clk_i) begin : check_interval
    interval_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (interval_q.size() == 0) begin
        $error("unexpected result: symbol_out %0d", symbol_out_o);
        mismatches++;
      end else begin
        want = interval_q.pop_front();
        if (symbol_out_o !== want.sym) begin
          $error("symbol_out: expected %0d, got %0d", want.sym, symbol_out_o);
          mismatches++;
        end
        if (cum_low_o !== want.lo) begin
          $error("cum_low: expected %0d, got %0d", want.lo, cum_low_o);
          mismatches++;
        end
        if (cum_high_o !== want.hi) begin
          $error("cum_high: expected %0d, got %0d", want.hi, cum_high_o);
          mismatches++;
        end
        if (total_o !== want.tot) begin
          $error("total: expected %0d, got %0d", want.tot, total_o);
          mismatches++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %0d, got %0d", want.err, error_o);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    #(20ms);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
